/* rtl/core/ueu_pkg.sv */
// Package for the unicode escape to UTF-8 unescaper core.
// Holds the byte and UTF-8 constants, the result buffer type and the hex digit helper.
// It has no dependencies.
package ueu_pkg;

  localparam int unsigned HEX_DIGITS  = 4;
  localparam int unsigned HEX_REM_W   = 3;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W   = 3;

  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_U         = 8'h75;
  localparam logic [7:0] CHR_LBRACE    = 8'h7B;
  localparam logic [7:0] CHR_RBRACE    = 8'h7D;
  localparam logic [7:0] CHR_NUL       = 8'h00;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam logic [CODE_W-1:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [CODE_W-1:0] TWO_BYTE_MAX = 16'h07FF;

  typedef logic [7:0] byte_t;
  typedef byte_t res_buf_t [MAX_RESULTS];

  // Bit 4 marks a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input byte_t b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* rtl/core/unicode_escape_to_utf8_unescaper_core.sv */
// Unicode escape to UTF-8 unescaper: byte stream in, unescaped UTF-8 byte stream out.
// Each accepted byte is decoded into a burst of up to four result bytes.
// The first result of a byte, if any, is offered from the registered output buffer in the cycle after its transfer.
// Throughput: one input byte per cycle while each byte yields at most one result and m_tready
// is high; a byte yielding more results holds off the next input until its last result is taken.
// Reset (rst, synchronous) empties the output buffer and clears all decode state.
module unicode_escape_to_utf8_unescaper_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ueu_pkg::byte_t       s_tdata,   // [7:0] in_byte
  input  logic                 s_tlast,   // in_last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ueu_pkg::byte_t       m_tdata,   // [7:0] out_byte
  output logic                 m_tlast,   // run_end
  output logic                 m_tuser    // [0] string_end
);
  import ueu_pkg::*;

  logic                 pending_valid, pending_valid_next;
  byte_t                pending_byte, pending_byte_next;
  logic [HEX_REM_W-1:0] hex_remaining, hex_remaining_next;
  logic [CODE_W-1:0]    hex_accum, hex_accum_next;
  logic                 hex_stopped, hex_stopped_next;
  logic                 hex_seen_digit, hex_seen_digit_next;
  logic [CODE_W-1:0]    previous_code, previous_code_next;

  res_buf_t             res_q, res_next;
  logic [RES_CNT_W-1:0] cnt_q, cnt_next;
  logic [RES_CNT_W-1:0] idx_q;
  logic                 term_q, term_next;

  logic                 s_acc, m_pop, m_done;
  logic                 esc;
  logic [CODE_W-1:0]    code;
  logic [4:0]           hv;

  assign m_tvalid = (cnt_q != '0);
  assign m_tdata  = res_q[idx_q];
  assign m_tlast  = (idx_q == cnt_q - RES_CNT_W'(1));
  assign m_tuser  = m_tlast && term_q;
  assign m_pop    = m_tvalid && m_tready;
  assign m_done   = m_pop && m_tlast;
  assign s_tready = (cnt_q == '0) || m_done;
  assign s_acc    = s_tvalid && s_tready;
  assign hv       = hex_value(s_tdata);

  always_comb begin
    pending_valid_next  = pending_valid;
    pending_byte_next   = pending_byte;
    hex_remaining_next  = hex_remaining;
    hex_accum_next      = hex_accum;
    hex_stopped_next    = hex_stopped;
    hex_seen_digit_next = hex_seen_digit;
    previous_code_next  = previous_code;
    res_next            = '{default: CHR_NUL};
    cnt_next            = '0;
    term_next           = 1'b0;
    esc                 = 1'b0;
    code                = previous_code;

    if (hex_remaining != '0) begin
      if (!hex_stopped && hv[4]) begin
        hex_accum_next      = {hex_accum[CODE_W-5:0], hv[3:0]};
        hex_seen_digit_next = 1'b1;
      end else begin
        hex_stopped_next = 1'b1;
      end
      hex_remaining_next = hex_remaining - HEX_REM_W'(1);
      esc = (hex_remaining_next == '0) || s_tlast;
    end else if (pending_valid) begin
      pending_valid_next = 1'b0;
      pending_byte_next  = CHR_NUL;
      if (pending_byte == CHR_BACKSLASH && s_tdata == CHR_U) begin
        hex_remaining_next  = HEX_REM_W'(HEX_DIGITS);
        hex_accum_next      = '0;
        hex_stopped_next    = 1'b0;
        hex_seen_digit_next = 1'b0;
        esc = s_tlast;
      end else if (pending_byte == CHR_BACKSLASH && s_tdata == CHR_QUOTE) begin
        res_next[cnt_next] = CHR_QUOTE;
        cnt_next = cnt_next + RES_CNT_W'(1);
      end else if (pending_byte == CHR_QUOTE && s_tdata == CHR_LBRACE) begin
        res_next[cnt_next] = CHR_LBRACE;
        cnt_next = cnt_next + RES_CNT_W'(1);
      end else if (pending_byte == CHR_RBRACE && s_tdata == CHR_QUOTE) begin
        res_next[cnt_next] = CHR_RBRACE;
        cnt_next = cnt_next + RES_CNT_W'(1);
      end else begin
        res_next[cnt_next] = pending_byte;
        cnt_next = cnt_next + RES_CNT_W'(1);
        pending_valid_next = 1'b1;
        pending_byte_next  = s_tdata;
      end
    end else begin
      pending_valid_next = 1'b1;
      pending_byte_next  = s_tdata;
    end

    if (esc) begin
      if (hex_seen_digit_next) begin
        previous_code_next = hex_accum_next;
      end
      code = hex_seen_digit_next ? hex_accum_next : previous_code;
      if (code <= ONE_BYTE_MAX) begin
        res_next[cnt_next] = {1'b0, code[6:0]};
        cnt_next = cnt_next + RES_CNT_W'(1);
      end else if (code <= TWO_BYTE_MAX) begin
        res_next[cnt_next] = UTF8_LEAD2 | {3'b000, code[10:6]};
        cnt_next = cnt_next + RES_CNT_W'(1);
        res_next[cnt_next] = UTF8_CONT | {2'b00, code[5:0]};
        cnt_next = cnt_next + RES_CNT_W'(1);
      end else begin
        res_next[cnt_next] = UTF8_LEAD3 | {4'b0000, code[15:12]};
        cnt_next = cnt_next + RES_CNT_W'(1);
        res_next[cnt_next] = UTF8_CONT | {2'b00, code[11:6]};
        cnt_next = cnt_next + RES_CNT_W'(1);
        res_next[cnt_next] = UTF8_CONT | {2'b00, code[5:0]};
        cnt_next = cnt_next + RES_CNT_W'(1);
      end
      hex_remaining_next  = '0;
      hex_accum_next      = '0;
      hex_stopped_next    = 1'b0;
      hex_seen_digit_next = 1'b0;
    end

    if (s_tlast) begin
      if (pending_valid_next) begin
        res_next[cnt_next] = pending_byte_next;
        cnt_next = cnt_next + RES_CNT_W'(1);
      end
      pending_valid_next  = 1'b0;
      pending_byte_next   = CHR_NUL;
      hex_remaining_next  = '0;
      hex_accum_next      = '0;
      hex_stopped_next    = 1'b0;
      hex_seen_digit_next = 1'b0;
      res_next[cnt_next]  = CHR_NUL;
      cnt_next  = cnt_next + RES_CNT_W'(1);
      term_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_byte   <= CHR_NUL;
      hex_remaining  <= '0;
      hex_accum      <= '0;
      hex_stopped    <= 1'b0;
      hex_seen_digit <= 1'b0;
      previous_code  <= '0;
    end else if (s_acc) begin
      pending_valid  <= pending_valid_next;
      pending_byte   <= pending_byte_next;
      hex_remaining  <= hex_remaining_next;
      hex_accum      <= hex_accum_next;
      hex_stopped    <= hex_stopped_next;
      hex_seen_digit <= hex_seen_digit_next;
      previous_code  <= previous_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      term_q <= 1'b0;
    end else if (s_acc) begin
      cnt_q  <= cnt_next;
      idx_q  <= '0;
      term_q <= term_next;
    end else if (m_done) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (m_pop) begin
      idx_q <= idx_q + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      res_q <= res_next;
    end
  end

  // The hex counter never exceeds the escape length.
  a_hex_range: assert property (@(posedge clk) disable iff (rst)
    hex_remaining <= HEX_REM_W'(HEX_DIGITS))
    else $error("hex counter out of range");

  // A transfer marked last leaves no held byte and no open escape behind.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> !pending_valid && hex_remaining == '0)
    else $error("state not cleared after last byte");

  // A transfer marked last always yields a burst that ends in the terminator.
  a_last_term: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> m_tvalid && term_q)
    else $error("missing terminator after last byte");

  // The terminator is always the final byte of its burst and carries a zero.
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == CHR_NUL)
    else $error("bad terminator");

  // The burst read position stays inside the filled part of the buffer.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> idx_q < cnt_q && cnt_q <= RES_CNT_W'(MAX_RESULTS))
    else $error("burst index out of range");

endmodule
